@@ design/assert_macros.svh @@
// Assertion macros shared by the reverb RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ACR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ACR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/acr_pkg.sv @@
// Shared widths, register indexes, control types and saturation helpers
// for the all-pass cascade reverb. No dependencies.
`timescale 1ns / 1ps

package acr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int SIG_W     = 18;
    localparam int PROD_W    = COEF_W + SIG_W;
    localparam int RND_W     = PROD_W + 1 - 15;
    localparam int SUM_W     = RND_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_DEPTH_ONE   = 1024;
    localparam int DEF_DEPTH_TWO   = 512;
    localparam int DEF_DEPTH_THREE = 256;
    localparam int DEF_DEPTH_FOUR  = 128;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd4;

    // Coefficient reset values (0.75, 0.70, 0.65, 0.60 in Q15)
    localparam logic signed [COEF_W-1:0] COEF1_RST = 16'sd24576;
    localparam logic signed [COEF_W-1:0] COEF2_RST = 16'sd22938;
    localparam logic signed [COEF_W-1:0] COEF3_RST = 16'sd21299;
    localparam logic signed [COEF_W-1:0] COEF4_RST = 16'sd19661;

    // Control for the shared multiply / round / accumulate unit
    typedef struct packed {
        logic mul_en;
        logic sub;
    } t_mac_ctrl;

    // Clamp a wide sum into the 18-bit stage range
    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 <<< (SIG_W - 1)) - 1);
        lo = -SUM_W'(1 <<< (SIG_W - 1));
        if (v > hi) begin
            return SIG_W'(hi);
        end else if (v < lo) begin
            return SIG_W'(lo);
        end
        return v[SIG_W-1:0];
    endfunction

    // Clamp a stage value to Q15
    function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [SIG_W-1:0] v);
        logic signed [SIG_W-1:0] hi;
        logic signed [SIG_W-1:0] lo;
        hi = SIG_W'((1 <<< (SAMPLE_W - 1)) - 1);
        lo = -SIG_W'(1 <<< (SAMPLE_W - 1));
        if (v > hi) begin
            return SAMPLE_W'(hi);
        end else if (v < lo) begin
            return SAMPLE_W'(lo);
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

@@ design/acr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module acr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/acr_mac.sv @@
// Shared arithmetic unit: registered Q15 coefficient product, then
// round-half-up, add or subtract against an addend, and 18-bit saturation.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_mac
    import acr_pkg::*;
(
    input  logic                      i_clk,
    input  t_mac_ctrl                 i_ctrl,
    input  logic signed [COEF_W-1:0]  i_coef,
    input  logic signed [SIG_W-1:0]   i_operand,
    input  logic signed [SIG_W-1:0]   i_addend,
    output logic signed [SIG_W-1:0]   o_result
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W:0]   w_biased;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [SUM_W-1:0]  w_sum;

    // Capture the product when asked
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_operand;
        end
    end

    // Round to Q15 (floor after adding half an LSB), then combine and clamp
    always_comb begin
        w_biased = (PROD_W+1)'(r_prod) + (PROD_W+1)'(1 <<< 14);
        w_rnd    = w_biased[PROD_W:15];
        if (i_ctrl.sub) begin
            w_sum = SUM_W'(i_addend) - SUM_W'(w_rnd);
        end else begin
            w_sum = SUM_W'(i_addend) + SUM_W'(w_rnd);
        end
        o_result = sat_sig(w_sum);
    end

endmodule

@@ design/allpass_cascade_reverb.sv @@
// Four-stage all-pass reverb on signed Q15 samples: top-level sequencer,
// configuration registers, delay-line RAMs and output register.
// Depends on acr_pkg, acr_ram, acr_mac and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each accepted sample runs through four cascaded all-pass stages that share
// one multiplier: every stage runs four steps (product k*in, subtract from
// the delayed entry, product k*out, write-back), then a finish step registers
// the output beat; the input is ready again once the block is back in idle
// and the output slot is free. With enable at 0 a sample is copied to the
// output register in the accept cycle. Delay-line entries never written
// read as zero (a per-line wrap flag), so there is no clearing pass after
// reset. Configuration writes are registered and are meant to happen only
// while the block is idle.
module allpass_cascade_reverb
    import acr_pkg::*;
#(
    parameter int DEPTH_ONE   = DEF_DEPTH_ONE,
    parameter int DEPTH_TWO   = DEF_DEPTH_TWO,
    parameter int DEPTH_THREE = DEF_DEPTH_THREE,
    parameter int DEPTH_FOUR  = DEF_DEPTH_FOUR
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COEF_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] sample_in
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [15:0] sample_out
);

    localparam int AW1 = $clog2(DEPTH_ONE);
    localparam int AW2 = $clog2(DEPTH_TWO);
    localparam int AW3 = $clog2(DEPTH_THREE);
    localparam int AW4 = $clog2(DEPTH_FOUR);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_SUB,
        S_MUL2,
        S_ADD,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        STG_ONE,
        STG_TWO,
        STG_THREE,
        STG_FOUR
    } t_stage;

    t_state                   r_state;
    t_stage                   r_stage;
    logic                     r_enable;
    logic signed [COEF_W-1:0] r_coef1;
    logic signed [COEF_W-1:0] r_coef2;
    logic signed [COEF_W-1:0] r_coef3;
    logic signed [COEF_W-1:0] r_coef4;
    logic signed [SIG_W-1:0]  r_x;
    logic signed [SIG_W-1:0]  r_y;
    logic [AW1-1:0]           r_pos1;
    logic [AW2-1:0]           r_pos2;
    logic [AW3-1:0]           r_pos3;
    logic [AW4-1:0]           r_pos4;
    logic [3:0]               r_full;
    logic                     r_out_valid;
    logic [SAMPLE_W-1:0]      r_out_data;

    logic                     w_in_beat;
    logic                     w_slot_free;
    logic                     w_out_load;
    t_mac_ctrl                w_mac_ctrl;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [SIG_W-1:0]  w_operand;
    logic signed [SIG_W-1:0]  w_addend;
    logic signed [SIG_W-1:0]  w_result;
    logic signed [SIG_W-1:0]  w_delayed;
    logic [SIG_W-1:0]         w_rd1;
    logic [SIG_W-1:0]         w_rd2;
    logic [SIG_W-1:0]         w_rd3;
    logic [SIG_W-1:0]         w_rd4;
    logic [3:0]               w_we;

    // Handshake: take a sample only when idle and the output slot will be free
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_slot_free;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A new beat enters the output slot on a bypass accept or a finished sample
    assign w_out_load = (w_in_beat && !r_enable) || (r_state == S_FIN);

    // Select the coefficient and delayed entry of the current stage
    always_comb begin
        case (r_stage)
            STG_ONE: begin
                w_coef    = r_coef1;
                w_delayed = r_full[0] ? signed'(w_rd1) : '0;
            end
            STG_TWO: begin
                w_coef    = r_coef2;
                w_delayed = r_full[1] ? signed'(w_rd2) : '0;
            end
            STG_THREE: begin
                w_coef    = r_coef3;
                w_delayed = r_full[2] ? signed'(w_rd3) : '0;
            end
            default: begin
                w_coef    = r_coef4;
                w_delayed = r_full[3] ? signed'(w_rd4) : '0;
            end
        endcase
    end

    // Steer the shared unit
    always_comb begin
        w_mac_ctrl.mul_en = (r_state == S_MUL1) || (r_state == S_MUL2);
        w_mac_ctrl.sub    = (r_state == S_SUB);
        w_operand         = (r_state == S_MUL2) ? r_y : r_x;
        w_addend          = (r_state == S_SUB) ? w_delayed : r_x;
        w_we              = '0;
        if (r_state == S_ADD) begin
            w_we[r_stage] = 1'b1;
        end
    end

    acr_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_mac_ctrl),
        .i_coef    (w_coef),
        .i_operand (w_operand),
        .i_addend  (w_addend),
        .o_result  (w_result)
    );

    acr_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH_ONE)) u_line1 (
        .i_clk   (i_clk),
        .i_we    (w_we[0]),
        .i_waddr (r_pos1),
        .i_wdata (w_result),
        .i_raddr (r_pos1),
        .o_rdata (w_rd1)
    );

    acr_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH_TWO)) u_line2 (
        .i_clk   (i_clk),
        .i_we    (w_we[1]),
        .i_waddr (r_pos2),
        .i_wdata (w_result),
        .i_raddr (r_pos2),
        .o_rdata (w_rd2)
    );

    acr_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH_THREE)) u_line3 (
        .i_clk   (i_clk),
        .i_we    (w_we[2]),
        .i_waddr (r_pos3),
        .i_wdata (w_result),
        .i_raddr (r_pos3),
        .o_rdata (w_rd3)
    );

    acr_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH_FOUR)) u_line4 (
        .i_clk   (i_clk),
        .i_we    (w_we[3]),
        .i_waddr (r_pos4),
        .i_wdata (w_result),
        .i_raddr (r_pos4),
        .o_rdata (w_rd4)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_coef1  <= COEF1_RST;
            r_coef2  <= COEF2_RST;
            r_coef3  <= COEF3_RST;
            r_coef4  <= COEF4_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_COEF1:  r_coef1  <= signed'(i_cfg_data);
                REG_COEF2:  r_coef2  <= signed'(i_cfg_data);
                REG_COEF3:  r_coef3  <= signed'(i_cfg_data);
                REG_COEF4:  r_coef4  <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer, stage registers, positions and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= STG_ONE;
            r_pos1      <= '0;
            r_pos2      <= '0;
            r_pos3      <= '0;
            r_pos4      <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drain the output slot unless a new beat lands in it
            if (r_out_valid && m_axis_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        if (r_enable) begin
                            r_x     <= SIG_W'(signed'(s_axis_tdata));
                            r_stage <= STG_ONE;
                            r_state <= S_MUL1;
                        end else begin
                            r_out_data  <= s_axis_tdata;
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_MUL1: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_y     <= w_result;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // Advance the position of the stage just written, wrap at depth
                    case (r_stage)
                        STG_ONE: begin
                            if (r_pos1 == AW1'(DEPTH_ONE - 1)) begin
                                r_pos1    <= '0;
                                r_full[0] <= 1'b1;
                            end else begin
                                r_pos1 <= r_pos1 + 1'b1;
                            end
                        end
                        STG_TWO: begin
                            if (r_pos2 == AW2'(DEPTH_TWO - 1)) begin
                                r_pos2    <= '0;
                                r_full[1] <= 1'b1;
                            end else begin
                                r_pos2 <= r_pos2 + 1'b1;
                            end
                        end
                        STG_THREE: begin
                            if (r_pos3 == AW3'(DEPTH_THREE - 1)) begin
                                r_pos3    <= '0;
                                r_full[2] <= 1'b1;
                            end else begin
                                r_pos3 <= r_pos3 + 1'b1;
                            end
                        end
                        default: begin
                            if (r_pos4 == AW4'(DEPTH_FOUR - 1)) begin
                                r_pos4    <= '0;
                                r_full[3] <= 1'b1;
                            end else begin
                                r_pos4 <= r_pos4 + 1'b1;
                            end
                        end
                    endcase
                    r_x <= r_y;
                    if (r_stage == STG_FOUR) begin
                        r_state <= S_FIN;
                    end else begin
                        r_stage <= t_stage'(r_stage + 2'd1);
                        r_state <= S_MUL1;
                    end
                end
                S_FIN: begin
                    r_out_data  <= sat_q15(r_x);
                    r_out_valid <= 1'b1;
                    r_stage     <= STG_ONE;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A reverb sample must find the output slot empty when it finishes
    `ACR_ASSERT_IMP(a_fin_slot_free, r_state == S_FIN, !r_out_valid)
    // An enabled accept starts the first stage
    `ACR_ASSERT_NXT(a_start_stage, w_in_beat && r_enable, r_state == S_MUL1 && r_stage == STG_ONE)
    // The stage counter is parked while idle
    `ACR_ASSERT_IMP(a_idle_stage, r_state == S_IDLE, r_stage == STG_ONE)
    // Write-back happens only in the write-back step
    `ACR_ASSERT_IMP(a_we_onehot, w_we != 4'd0, r_state == S_ADD && $onehot(w_we))

endmodule
